// ===== sv/ssis_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the two-coin stableswap invariant solver.
// Holds field widths and status codes; depends on nothing else.
package ssis_pkg;

  localparam int BAL_WIDTH    = 62;
  localparam int AMP_WIDTH    = 20;
  localparam int OUT_WIDTH    = 64;
  localparam int STATUS_WIDTH = 3;
  localparam int COUNT_WIDTH  = 8;

  typedef logic [STATUS_WIDTH-1:0] status_t;

  localparam status_t ST_CONVERGED = 3'd0;
  localparam status_t ST_CYCLE     = 3'd1;
  localparam status_t ST_EMPTY     = 3'd2;
  localparam status_t ST_ONE_SIDE  = 3'd3;
  localparam status_t ST_NO_CONV   = 3'd4;
  localparam status_t ST_SATURATED = 3'd5;

endpackage

// ===== sv/ssis_mul.sv =====
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier, product truncated to W bits.
// Takes one multiplier bit per cycle, MSB first; no dependencies.
module ssis_mul #(
  parameter int W = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         done,
  output logic [W-1:0] product
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  acc_r, a_r, b_r;
  logic [CW-1:0] cnt_r;
  logic          done_r;

  // One shift-add step: double the partial product and add the multiplicand.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        acc_r <= '0;
        a_r   <= a;
        b_r   <= b;
        cnt_r <= CW'(W);
      end else if (cnt_r != '0) begin
        acc_r <= {acc_r[W-2:0], 1'b0} + (b_r[W-1] ? a_r : '0);
        b_r   <= {b_r[W-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

// ===== sv/ssis_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, W-bit operands.
// A zero divisor yields an all-ones quotient; no dependencies.
module ssis_div #(
  parameter int W = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r, num_r, den_r;
  logic [CW-1:0] cnt_r;
  logic          done_r;
  logic [W:0]    rem_sh;
  logic [W:0]    rem_diff;
  logic          q_bit;

  // Shift in the next dividend bit and subtract when the divisor fits.
  always_comb begin
    rem_sh   = {rem_r, num_r[W-1]};
    rem_diff = rem_sh - {1'b0, den_r};
    q_bit    = (rem_sh >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= '0;
        num_r <= dividend;
        den_r <= divisor;
        cnt_r <= CW'(W);
      end else if (cnt_r != '0) begin
        rem_r <= q_bit ? rem_diff[W-1:0] : rem_sh[W-1:0];
        num_r <= {num_r[W-2:0], q_bit};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = num_r;

endmodule

// ===== sv/stableswap_invariant_solver_unit.sv =====
`timescale 1ns / 1ps
// Sequence: each Newton iteration runs four serial multiplies and three serial divisions
// through the shared units, then the convergence check, a scan of the window and an insert;
// one setup multiply comes before the first iteration, and the output register is loaded
// after the last. An empty side skips the Newton steps and goes straight to the output.
// Throughput: one item at a time; the shared bit-serial multiplier and divider set it.
// Reset: synchronous active-low rst_n clears the sequencer and the output valid.
// Top level; uses ssis_pkg, ssis_mul and ssis_div.
module stableswap_invariant_solver_unit #(
  parameter int MAX_ITERATIONS     = 255,
  parameter int CYCLE_WINDOW_DEPTH = 32,
  parameter int WORK_WIDTH         = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ssis_pkg::BAL_WIDTH-1:0]      in_balance_x,
  input  logic [ssis_pkg::BAL_WIDTH-1:0]      in_balance_y,
  input  logic [ssis_pkg::AMP_WIDTH-1:0]      in_amp_coefficient,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ssis_pkg::OUT_WIDTH-1:0]      out_invariant_d,
  output logic [ssis_pkg::STATUS_WIDTH-1:0]   out_status,
  output logic [ssis_pkg::COUNT_WIDTH-1:0]    out_iteration_count
);

  localparam int W  = WORK_WIDTH;
  localparam int DP = CYCLE_WINDOW_DEPTH;
  localparam int AW = $clog2(DP);
  localparam int OW = ssis_pkg::OUT_WIDTH;
  localparam int CN = ssis_pkg::COUNT_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_AS, S_MUL_DD, S_DIV_X, S_MUL_PD, S_DIV_Y, S_MUL_NUM, S_MUL_DEN,
    S_DIV_D, S_CHECK, S_SCAN_RD, S_SCAN_CMP, S_MAX_RD, S_MAX_CMP, S_INSERT, S_EMIT
  } state_t;

  state_t state_r;

  logic [W-1:0] d_r, prev_r, annm1_r, tx_r, ty_r, as_r, num_r, p3_r, best_r;
  logic [W-1:0] mul_a_r, mul_b_r, div_n_r, div_d_r;
  logic         mul_start_r, div_start_r;
  logic         mul_done, div_done;
  logic [W-1:0] mul_res, div_res;

  logic [CN-1:0] iter_r;
  logic [AW:0]   fill_r;
  logic [AW-1:0] base_r, k_r;

  logic [W-1:0]  win_mem [DP];
  logic [W-1:0]  rd_data_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;

  logic [W-1:0]              fin_d_r;
  ssis_pkg::status_t         fin_st_r;
  logic                      out_valid_r;
  logic [OW-1:0]             out_d_r;
  ssis_pkg::status_t         out_st_r;
  logic [CN-1:0]             out_cnt_r;

  logic [W-1:0] diff;
  logic [AW:0]  k_next;

  // Circular window addressing: the oldest entry sits at base_r.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW:0] b);
    logic [AW+1:0] sum;
    sum = {2'b00, a} + {1'b0, b};
    if (sum >= (AW+2)'(DP)) begin
      sum = sum - (AW+2)'(DP);
    end
    return sum[AW-1:0];
  endfunction

  ssis_mul #(.W(W)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start_r), .a(mul_a_r), .b(mul_b_r),
    .done(mul_done), .product(mul_res)
  );

  ssis_div #(.W(W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start_r), .dividend(div_n_r), .divisor(div_d_r),
    .done(div_done), .quotient(div_res)
  );

  // Distance between successive iterates and window bookkeeping.
  always_comb begin
    diff    = (d_r > prev_r) ? (d_r - prev_r) : (prev_r - d_r);
    k_next  = {1'b0, k_r} + 1'b1;
    rd_addr = wrap_add(base_r, {1'b0, k_r});
    wr_addr = (fill_r < (AW+1)'(DP)) ? wrap_add(base_r, fill_r) : base_r;
    wr_en   = (state_r == S_INSERT);
  end

  // Window memory with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      win_mem[wr_addr] <= d_r;
    end
    rd_data_r <= win_mem[rd_addr];
  end

  // Sequencer: one Newton step through the shared units, then the window check.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            iter_r <= '0;
            fill_r <= '0;
            base_r <= '0;
            if (in_balance_x == '0 || in_balance_y == '0) begin
              fin_d_r  <= '0;
              fin_st_r <= (in_balance_x == '0 && in_balance_y == '0) ?
                          ssis_pkg::ST_EMPTY : ssis_pkg::ST_ONE_SIDE;
              state_r  <= S_EMIT;
            end else begin
              d_r     <= W'({1'b0, in_balance_x} + {1'b0, in_balance_y});
              annm1_r <= W'({in_amp_coefficient, 1'b0}) - W'(1);
              tx_r    <= W'({in_balance_x, 1'b0});
              ty_r    <= W'({in_balance_y, 1'b0});
              mul_a_r <= W'({in_amp_coefficient, 1'b0});
              mul_b_r <= W'({1'b0, in_balance_x} + {1'b0, in_balance_y});
              mul_start_r <= 1'b1;
              state_r <= S_MUL_AS;
            end
          end
        end
        S_MUL_AS: begin
          if (mul_done) begin
            as_r        <= mul_res;
            mul_a_r     <= d_r;
            mul_b_r     <= d_r;
            mul_start_r <= 1'b1;
            state_r     <= S_MUL_DD;
          end
        end
        S_MUL_DD: begin
          if (mul_done) begin
            div_n_r     <= mul_res;
            div_d_r     <= tx_r;
            div_start_r <= 1'b1;
            state_r     <= S_DIV_X;
          end
        end
        S_DIV_X: begin
          if (div_done) begin
            mul_a_r     <= div_res;
            mul_b_r     <= d_r;
            mul_start_r <= 1'b1;
            state_r     <= S_MUL_PD;
          end
        end
        S_MUL_PD: begin
          if (mul_done) begin
            div_n_r     <= mul_res;
            div_d_r     <= ty_r;
            div_start_r <= 1'b1;
            state_r     <= S_DIV_Y;
          end
        end
        S_DIV_Y: begin
          if (div_done) begin
            p3_r        <= {div_res[W-2:0], 1'b0} + div_res;
            mul_a_r     <= as_r + {div_res[W-2:0], 1'b0};
            mul_b_r     <= d_r;
            mul_start_r <= 1'b1;
            state_r     <= S_MUL_NUM;
          end
        end
        S_MUL_NUM: begin
          if (mul_done) begin
            num_r       <= mul_res;
            mul_a_r     <= annm1_r;
            mul_b_r     <= d_r;
            mul_start_r <= 1'b1;
            state_r     <= S_MUL_DEN;
          end
        end
        S_MUL_DEN: begin
          if (mul_done) begin
            div_n_r     <= num_r;
            div_d_r     <= mul_res + p3_r;
            div_start_r <= 1'b1;
            state_r     <= S_DIV_D;
          end
        end
        S_DIV_D: begin
          if (div_done) begin
            prev_r  <= d_r;
            d_r     <= div_res;
            iter_r  <= iter_r + 1'b1;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          k_r <= '0;
          if (diff <= W'(1)) begin
            fin_d_r  <= d_r;
            fin_st_r <= ssis_pkg::ST_CONVERGED;
            state_r  <= S_EMIT;
          end else if (fill_r == '0) begin
            state_r <= S_INSERT;
          end else begin
            state_r <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          state_r <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          if (rd_data_r == d_r) begin
            best_r  <= d_r;
            state_r <= S_MAX_RD;
          end else begin
            k_r     <= k_next[AW-1:0];
            state_r <= (k_next == fill_r) ? S_INSERT : S_SCAN_RD;
          end
        end
        S_MAX_RD: begin
          state_r <= S_MAX_CMP;
        end
        S_MAX_CMP: begin
          k_r <= k_next[AW-1:0];
          if (k_next == fill_r) begin
            fin_d_r  <= (rd_data_r > best_r) ? rd_data_r : best_r;
            fin_st_r <= ssis_pkg::ST_CYCLE;
            state_r  <= S_EMIT;
          end else begin
            if (rd_data_r > best_r) begin
              best_r <= rd_data_r;
            end
            state_r <= S_MAX_RD;
          end
        end
        S_INSERT: begin
          if (fill_r < (AW+1)'(DP)) begin
            fill_r <= fill_r + 1'b1;
          end else begin
            base_r <= wrap_add(base_r, (AW+1)'(1));
          end
          if (iter_r == CN'(MAX_ITERATIONS)) begin
            fin_d_r  <= '0;
            fin_st_r <= ssis_pkg::ST_NO_CONV;
            state_r  <= S_EMIT;
          end else begin
            mul_a_r     <= d_r;
            mul_b_r     <= d_r;
            mul_start_r <= 1'b1;
            state_r     <= S_MUL_DD;
          end
        end
        S_EMIT: begin
          // Load the output register once the previous result has been taken.
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_cnt_r   <= iter_r;
            if (fin_d_r[W-1:OW] != '0) begin
              out_d_r  <= '1;
              out_st_r <= ssis_pkg::ST_SATURATED;
            end else begin
              out_d_r  <= fin_d_r[OW-1:0];
              out_st_r <= fin_st_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready            = (state_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_invariant_d     = out_d_r;
  assign out_status          = out_st_r;
  assign out_iteration_count = out_cnt_r;

endmodule

// ===== sim/tb_stableswap_invariant_solver_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for stableswap_invariant_solver_unit: directed and random pool items,
// with expected D, status and iteration count from a 256-bit predictor written here.
// Depends on ssis_pkg and the solver RTL.
module tb_stableswap_invariant_solver_unit;

  localparam int    NUM_RANDOM = 300;
  localparam int    MAX_ITER   = 255;
  localparam int    WIN_DEPTH  = 32;
  localparam int    WIDE       = 256;
  localparam int    AMP_MAX    = 1000000;
  localparam int    TAIL_WAIT  = 400;
  localparam real   RUN_LIMIT  = 1.0e10;

  typedef logic [WIDE-1:0] wide_t;
  typedef logic [ssis_pkg::BAL_WIDTH-1:0] bal_t;
  typedef logic [ssis_pkg::AMP_WIDTH-1:0] amp_t;

  typedef struct {
    bal_t bx;
    bal_t by;
    amp_t amp;
    bit   drain_first;
  } pool_item_t;

  typedef struct {
    logic [ssis_pkg::OUT_WIDTH-1:0]   d;
    ssis_pkg::status_t                st;
    logic [ssis_pkg::COUNT_WIDTH-1:0] cnt;
  } invariant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  bal_t in_balance_x = '0;
  bal_t in_balance_y = '0;
  amp_t in_amp_coefficient = 20'd1;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ssis_pkg::OUT_WIDTH-1:0] out_invariant_d;
  logic [ssis_pkg::STATUS_WIDTH-1:0] out_status;
  logic [ssis_pkg::COUNT_WIDTH-1:0] out_iteration_count;

  pool_item_t pending_items[$];
  invariant_t expected_invariants[$];
  int         send_gap = 0;
  int         recv_gap = 0;
  int         num_errors = 0;
  int         num_checked = 0;
  int         status_seen[6];

  stableswap_invariant_solver_unit i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_balance_x        (in_balance_x),
    .in_balance_y        (in_balance_y),
    .in_amp_coefficient  (in_amp_coefficient),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_invariant_d     (out_invariant_d),
    .out_status          (out_status),
    .out_iteration_count (out_iteration_count)
  );

  // Clock generation.
  initial begin
    forever #5 clk = ~clk;
  end

  // Truncating division; a zero divisor yields all ones like a restoring divider.
  function automatic wide_t wide_div(wide_t n, wide_t dv);
    if (dv == '0) begin
      return '1;
    end
    return n / dv;
  endfunction

  // Saturates D to the output width and packs the result fields.
  function automatic invariant_t pack_invariant(wide_t d, ssis_pkg::status_t st, int cnt);
    invariant_t r;
    if (d[WIDE-1:ssis_pkg::OUT_WIDTH] != '0) begin
      r.d  = '1;
      r.st = ssis_pkg::ST_SATURATED;
    end else begin
      r.d  = d[ssis_pkg::OUT_WIDTH-1:0];
      r.st = st;
    end
    r.cnt = cnt[ssis_pkg::COUNT_WIDTH-1:0];
    return r;
  endfunction

  // Newton solve of the two-coin invariant with limit-cycle detection.
  function automatic invariant_t solve_invariant(bal_t bx, bal_t by, amp_t amp);
    wide_t      iter_window[WIN_DEPTH];
    int         filled;
    wide_t      s, ann, annm1, tx, ty, d, p, prev, num, den, diff, best;
    invariant_t r;
    filled = 0;
    if (bx == '0 && by == '0) begin
      r.d = '0; r.st = ssis_pkg::ST_EMPTY; r.cnt = '0;
      return r;
    end
    if (bx == '0 || by == '0) begin
      r.d = '0; r.st = ssis_pkg::ST_ONE_SIDE; r.cnt = '0;
      return r;
    end
    s     = wide_t'(bx) + wide_t'(by);
    ann   = wide_t'(amp) * 2;
    annm1 = ann - 1;
    tx    = wide_t'(bx) * 2;
    ty    = wide_t'(by) * 2;
    d     = s;
    for (int i = 0; i < MAX_ITER; i++) begin
      p    = wide_div(wide_t'(d * d), tx);
      p    = wide_div(wide_t'(p * d), ty);
      prev = d;
      num  = wide_t'(ann * s) + wide_t'(p * 2);
      num  = num * d;
      den  = wide_t'(annm1 * d) + wide_t'(p * 3);
      d    = wide_div(num, den);
      diff = (d > prev) ? d - prev : prev - d;
      if (diff <= 1) begin
        return pack_invariant(d, ssis_pkg::ST_CONVERGED, i + 1);
      end
      // Oldest-first search; on a repeat take the largest iterate from the match on.
      for (int k = 0; k < filled; k++) begin
        if (iter_window[k] == d) begin
          best = d;
          for (int j = k; j < filled; j++) begin
            if (iter_window[j] > best) best = iter_window[j];
          end
          return pack_invariant(best, ssis_pkg::ST_CYCLE, i + 1);
        end
      end
      if (filled < WIN_DEPTH) begin
        iter_window[filled] = d;
        filled++;
      end else begin
        for (int k = 1; k < WIN_DEPTH; k++) iter_window[k-1] = iter_window[k];
        iter_window[WIN_DEPTH-1] = d;
      end
    end
    r.d = '0; r.st = ssis_pkg::ST_NO_CONV; r.cnt = ssis_pkg::COUNT_WIDTH'(MAX_ITER);
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(5, 1);
    return $urandom_range(300, 20);
  endfunction

  function automatic bal_t rand_balance();
    return bal_t'({$urandom, $urandom});
  endfunction

  function automatic amp_t rand_amp();
    if ($urandom_range(1) == 0) return amp_t'($urandom_range(1000, 1));
    return amp_t'($urandom_range(AMP_MAX, 1));
  endfunction

  task automatic add_item(bal_t bx, bal_t by, amp_t amp, bit drain_first);
    pool_item_t it;
    it.bx = bx; it.by = by; it.amp = amp; it.drain_first = drain_first;
    pending_items.push_back(it);
  endtask

  // Driver: predict on each transfer, then present the next item after a random gap.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_invariants.push_back(
          solve_invariant(in_balance_x, in_balance_y, in_amp_coefficient));
      end
      if (in_valid && !in_ready) begin
        // Hold the item until it is taken.
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0 &&
                   (!pending_items[0].drain_first || expected_invariants.size() == 0)) begin
        in_balance_x       <= pending_items[0].bx;
        in_balance_y       <= pending_items[0].by;
        in_amp_coefficient <= pending_items[0].amp;
        in_valid           <= 1'b1;
        void'(pending_items.pop_front());
        send_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure, and every result transfer checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_invariants.size() == 0) begin
          $display("%0t: unexpected result d=%0h status=%0d count=%0d", $time,
                   out_invariant_d, out_status, out_iteration_count);
          num_errors++;
        end else begin
          if (out_invariant_d !== expected_invariants[0].d) begin
            $display("%0t: invariant_d expected %0h actual %0h", $time,
                     expected_invariants[0].d, out_invariant_d);
            num_errors++;
          end
          if (out_status !== expected_invariants[0].st) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     expected_invariants[0].st, out_status);
            num_errors++;
          end
          if (out_iteration_count !== expected_invariants[0].cnt) begin
            $display("%0t: iteration_count expected %0d actual %0d", $time,
                     expected_invariants[0].cnt, out_iteration_count);
            num_errors++;
          end
          if (expected_invariants[0].st <= ssis_pkg::ST_SATURATED) begin
            status_seen[expected_invariants[0].st]++;
          end
          num_checked++;
          void'(expected_invariants.pop_front());
        end
      end
      if (recv_gap > 0) begin
        recv_gap  <= recv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_gap  <= ($urandom_range(3) == 0) ? pick_gap() : 0;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    bal_t bx, by;
    int   mode;
    bal_t bal_max;
    bal_max = '1;
    // Directed: empty cases, field extremes, balanced and skewed pools.
    add_item('0, '0, 20'd1, 1'b0);
    add_item('0, bal_max, amp_t'(AMP_MAX), 1'b0);
    add_item(bal_max, '0, 20'd1, 1'b0);
    add_item('0, 62'd5, 20'd77, 1'b0);
    add_item(62'd1, 62'd1, 20'd1, 1'b0);
    add_item(62'd1, 62'd2, 20'd1, 1'b0);
    add_item(62'd2, 62'd1, amp_t'(AMP_MAX), 1'b0);
    add_item(bal_max, bal_max, 20'd1, 1'b0);
    add_item(bal_max, bal_max, amp_t'(AMP_MAX), 1'b0);
    add_item(bal_max, bal_max - 1, 20'd100, 1'b0);
    add_item(62'd1, bal_max, 20'd1, 1'b0);
    add_item(bal_max, 62'd1, amp_t'(AMP_MAX), 1'b0);
    add_item(62'd3, 62'd1000000, 20'd2, 1'b0);
    add_item(62'h2AAA_AAAA_AAAA_AAAA, 62'h1555_5555_5555_5555, 20'hAAAAA, 1'b0);
    add_item(62'h1555_5555_5555_5555, 62'h2AAA_AAAA_AAAA_AAAA, 20'h55555, 1'b0);
    add_item(62'd1000000000, 62'd1000000001, 20'd100, 1'b0);
    add_item(62'd7, 62'd7, 20'd1, 1'b0);
    // Random: mostly near-balanced pools, plus wide ratios, tiny pools and empty sides.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      mode = $urandom_range(99);
      bx = rand_balance();
      if (mode < 60) begin
        by = bx + bal_t'($urandom_range(1000)) - bal_t'($urandom_range(1000));
        if ($urandom_range(1)) by = bx - (bx >> $urandom_range(10, 2));
      end else if (mode < 80) begin
        by = rand_balance();
      end else if (mode < 92) begin
        bx = bal_t'($urandom_range(1000));
        by = bal_t'($urandom_range(1000));
      end else if (mode < 96) begin
        by = '0;
      end else begin
        by = bx;
        bx = '0;
      end
      add_item(bx, by, rand_amp(), n == NUM_RANDOM / 2);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_items.size() == 0 && !in_valid);
    wait (expected_invariants.size() == 0);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("Checked %0d results: converged %0d, cycle %0d, empty %0d, one side %0d,",
             num_checked, status_seen[ssis_pkg::ST_CONVERGED],
             status_seen[ssis_pkg::ST_CYCLE], status_seen[ssis_pkg::ST_EMPTY],
             status_seen[ssis_pkg::ST_ONE_SIDE]);
    $display("no convergence %0d, saturated %0d.", status_seen[ssis_pkg::ST_NO_CONV],
             status_seen[ssis_pkg::ST_SATURATED]);
    if (num_errors == 0 && expected_invariants.size() == 0) begin
      $display("stableswap_invariant_solver_unit regression: pass");
    end else begin
      $display("stableswap_invariant_solver_unit regression: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(RUN_LIMIT);
    $display("Timeout with %0d results outstanding.", expected_invariants.size());
    $display("stableswap_invariant_solver_unit regression: fail");
    $finish;
  end

endmodule

// ===== stableswap_invariant_solver_unit.f =====
sv/ssis_pkg.sv
sv/ssis_mul.sv
sv/ssis_div.sv
sv/stableswap_invariant_solver_unit.sv
sim/tb_stableswap_invariant_solver_unit.sv
